// ===== design/fprx_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fprx_pkg
// Shared types and constants for the framed packet receiver.
// ----------------------------------------------------------------------------
package fprx_pkg;

    localparam int PAYLOAD_BYTES_DEF = 8;
    localparam int BYTE_W            = 8;
    localparam int IDX_W             = 5;
    localparam int CNT_W             = 6;

    localparam logic [BYTE_W-1:0] START_DELIM = 8'h24;

    typedef enum logic [1:0] {
        PH_WAIT = 2'd0,
        PH_TYPE = 2'd1,
        PH_BODY = 2'd2,
        PH_DEAD = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        EM_IDLE = 2'd0,
        EM_READ = 2'd1,
        EM_SHOW = 2'd2
    } emit_state_t;

    typedef struct packed {
        logic [BYTE_W-1:0] frame_type;
        logic [BYTE_W-1:0] seq_num;
        logic [BYTE_W-1:0] received_check;
        logic              approved;
    } frame_info_t;

endpackage
`default_nettype wire

// ===== design/framed_packet_receiver_xor_check_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// framed_packet_receiver_xor_check_core
// Start-delimited frame receiver with XOR check over type, payload, sequence.
// ----------------------------------------------------------------------------
// Takes one byte per cycle while a frame is being parsed. When the check byte
// is taken, the input stalls while the payload is played out of the payload
// buffer, whose single read port delivers one entry per read: each result
// is read, then presented, and the input is held until the last result has
// been taken, including any time the output side stalls.
// ----------------------------------------------------------------------------
module framed_packet_receiver_xor_check_core #(
    parameter int PAYLOAD_BYTES = fprx_pkg::PAYLOAD_BYTES_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic [fprx_pkg::BYTE_W-1:0] rx_byte,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic      [fprx_pkg::BYTE_W-1:0] data_byte,
    output logic      [fprx_pkg::IDX_W-1:0]  byte_index,
    output logic      [fprx_pkg::BYTE_W-1:0] frame_type,
    output logic      [fprx_pkg::BYTE_W-1:0] seq_num,
    output logic      [fprx_pkg::BYTE_W-1:0] received_check,
    output logic                             approved,
    output logic                             last
);

    localparam int AW = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;

    logic                        take;
    logic                        busy;
    logic                        start;
    logic                        wr_en;
    logic [AW-1:0]               wr_addr;
    logic [fprx_pkg::BYTE_W-1:0] wr_data;
    logic                        rd_en;
    logic [AW-1:0]               rd_addr;
    fprx_pkg::frame_info_t       info;

    assign in_stall = busy;
    assign take     = in_valid && !busy;

    fprx_parse #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES),
        .AW            (AW)
    ) u_parse (
        .clk     (clk),
        .rst_n   (rst_n),
        .take    (take),
        .rx_byte (rx_byte),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .start   (start),
        .info    (info)
    );

    fprx_pbuf #(
        .DEPTH (PAYLOAD_BYTES),
        .AW    (AW)
    ) u_pbuf (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (data_byte)
    );

    fprx_emit #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES),
        .AW            (AW)
    ) u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .out_stall  (out_stall),
        .busy       (busy),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .out_valid  (out_valid),
        .byte_index (byte_index),
        .last       (last)
    );

    assign frame_type     = info.frame_type;
    assign seq_num        = info.seq_num;
    assign received_check = info.received_check;
    assign approved       = info.approved;

endmodule
`default_nettype wire

// ===== design/fprx_pbuf.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fprx_pbuf
// Payload buffer: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module fprx_pbuf #(
    parameter int DEPTH = fprx_pkg::PAYLOAD_BYTES_DEF,
    parameter int AW    = 3
) (
    input  wire logic                        clk,
    input  wire logic                        wr_en,
    input  wire logic [AW-1:0]               wr_addr,
    input  wire logic [fprx_pkg::BYTE_W-1:0] wr_data,
    input  wire logic                        rd_en,
    input  wire logic [AW-1:0]               rd_addr,
    output logic      [fprx_pkg::BYTE_W-1:0] rd_data
);

    logic [fprx_pkg::BYTE_W-1:0] mem [DEPTH];
    logic [fprx_pkg::BYTE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

// ===== design/fprx_parse.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fprx_parse
// Frame parser: delimiter hunt, type, payload writes, sequence, check compare.
// ----------------------------------------------------------------------------
module fprx_parse #(
    parameter int PAYLOAD_BYTES = fprx_pkg::PAYLOAD_BYTES_DEF,
    parameter int AW            = 3
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        take,
    input  wire logic [fprx_pkg::BYTE_W-1:0] rx_byte,
    output logic                             wr_en,
    output logic      [AW-1:0]               wr_addr,
    output logic      [fprx_pkg::BYTE_W-1:0] wr_data,
    output logic                             start,
    output fprx_pkg::frame_info_t            info
);

    localparam logic [fprx_pkg::CNT_W-1:0] CNT_SEQ   = fprx_pkg::CNT_W'(PAYLOAD_BYTES);
    localparam logic [fprx_pkg::CNT_W-1:0] CNT_CHECK = fprx_pkg::CNT_W'(PAYLOAD_BYTES + 1);

    fprx_pkg::phase_t              phase_reg, phase_next;
    logic [fprx_pkg::CNT_W-1:0]    body_count_reg, body_count_next;
    logic [fprx_pkg::BYTE_W-1:0]   type_reg, type_next;
    logic [fprx_pkg::BYTE_W-1:0]   seq_reg, seq_next;
    logic [fprx_pkg::BYTE_W-1:0]   check_reg, check_next;
    logic [fprx_pkg::BYTE_W-1:0]   rx_check_reg, rx_check_next;
    logic                          ok_reg, ok_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= fprx_pkg::PH_WAIT;
            body_count_reg <= '0;
            type_reg       <= '0;
            seq_reg        <= '0;
            check_reg      <= '0;
            rx_check_reg   <= '0;
            ok_reg         <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            body_count_reg <= body_count_next;
            type_reg       <= type_next;
            seq_reg        <= seq_next;
            check_reg      <= check_next;
            rx_check_reg   <= rx_check_next;
            ok_reg         <= ok_next;
        end
    end

    always_comb
    begin
        phase_next      = phase_reg;
        body_count_next = body_count_reg;
        type_next       = type_reg;
        seq_next        = seq_reg;
        check_next      = check_reg;
        rx_check_next   = rx_check_reg;
        ok_next         = ok_reg;
        if (take)
        begin
            case (phase_reg)
                fprx_pkg::PH_WAIT:
                begin
                    if (rx_byte == fprx_pkg::START_DELIM)
                    begin
                        body_count_next = '0;
                        check_next      = '0;
                        phase_next      = fprx_pkg::PH_TYPE;
                    end
                end
                fprx_pkg::PH_TYPE:
                begin
                    body_count_next = '0;
                    if (rx_byte != fprx_pkg::START_DELIM)
                    begin
                        type_next  = rx_byte;
                        check_next = rx_byte;
                        phase_next = fprx_pkg::PH_BODY;
                    end
                end
                fprx_pkg::PH_BODY:
                begin
                    if (body_count_reg < CNT_SEQ)
                    begin
                        check_next      = check_reg ^ rx_byte;
                        body_count_next = body_count_reg + 1'b1;
                    end
                    else if (body_count_reg == CNT_SEQ)
                    begin
                        seq_next        = rx_byte;
                        check_next      = check_reg ^ rx_byte;
                        body_count_next = body_count_reg + 1'b1;
                    end
                    else
                    begin
                        if (body_count_reg == CNT_CHECK)
                        begin
                            rx_check_next = rx_byte;
                            ok_next       = (rx_byte == check_reg);
                        end
                        body_count_next = '0;
                        phase_next      = fprx_pkg::PH_WAIT;
                    end
                end
                default:
                begin
                    body_count_next = '0;
                    phase_next      = fprx_pkg::PH_WAIT;
                end
            endcase
        end
    end

    always_comb
    begin
        wr_en = 1'b0;
        start = 1'b0;
        case (phase_reg)
            fprx_pkg::PH_BODY:
            begin
                wr_en = take && (body_count_reg < CNT_SEQ);
                start = take && (body_count_reg == CNT_CHECK);
            end
            default:
            begin
                wr_en = 1'b0;
                start = 1'b0;
            end
        endcase
    end

    assign wr_addr = body_count_reg[AW-1:0];
    assign wr_data = rx_byte;

    assign info.frame_type     = type_reg;
    assign info.seq_num        = seq_reg;
    assign info.received_check = rx_check_reg;
    assign info.approved       = ok_reg;

endmodule
`default_nettype wire

// ===== design/fprx_emit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fprx_emit
// Result sequencer: reads the payload buffer entry by entry and presents
// one result per payload byte.
// ----------------------------------------------------------------------------
module fprx_emit #(
    parameter int PAYLOAD_BYTES = fprx_pkg::PAYLOAD_BYTES_DEF,
    parameter int AW            = 3
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic                       out_stall,
    output logic                            busy,
    output logic                            rd_en,
    output logic     [AW-1:0]               rd_addr,
    output logic                            out_valid,
    output logic     [fprx_pkg::IDX_W-1:0]  byte_index,
    output logic                            last
);

    localparam logic [AW-1:0] IDX_LAST = AW'(PAYLOAD_BYTES - 1);

    fprx_pkg::emit_state_t state_reg, state_next;
    logic [AW-1:0]         idx_reg, idx_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fprx_pkg::EM_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        case (state_reg)
            fprx_pkg::EM_IDLE:
            begin
                if (start)
                begin
                    idx_next   = '0;
                    state_next = fprx_pkg::EM_READ;
                end
            end
            fprx_pkg::EM_READ:
            begin
                state_next = fprx_pkg::EM_SHOW;
            end
            fprx_pkg::EM_SHOW:
            begin
                if (!out_stall)
                begin
                    if (idx_reg == IDX_LAST)
                    begin
                        state_next = fprx_pkg::EM_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = fprx_pkg::EM_READ;
                    end
                end
            end
            default:
            begin
                state_next = fprx_pkg::EM_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rd_en     = 1'b0;
        out_valid = 1'b0;
        busy      = 1'b1;
        case (state_reg)
            fprx_pkg::EM_IDLE: busy = 1'b0;
            fprx_pkg::EM_READ: rd_en = 1'b1;
            fprx_pkg::EM_SHOW: out_valid = 1'b1;
            default:           busy = 1'b1;
        endcase
    end

    assign rd_addr    = idx_reg;
    assign byte_index = fprx_pkg::IDX_W'(idx_reg);
    assign last       = (idx_reg == IDX_LAST);

endmodule
`default_nettype wire

// ===== tb/tb_framed_packet_receiver_xor_check_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_framed_packet_receiver_xor_check_core
// Self-checking bench for the delimited frame receiver with XOR check.
// ----------------------------------------------------------------------------
// Byte transfers go in through a random-gap sender. A local frame parser
// predicts the payload playout of every completed frame, and each output
// transfer is checked field by field against the oldest prediction. Tests
// cover directed corner frames, random well-formed, noisy and truncated
// traffic under several idle/stall mixes, and a long output hold-off that
// backs the block up into its input.
// ----------------------------------------------------------------------------
module tb_framed_packet_receiver_xor_check_core;

    localparam int NB    = fprx_pkg::PAYLOAD_BYTES_DEF;
    localparam int NB_AW = (NB > 1) ? $clog2(NB) : 1;

    typedef struct {
        logic [7:0] data;
        logic [4:0] idx;
        logic [7:0] ftype;
        logic [7:0] seq;
        logic [7:0] chk;
        logic       ok;
        logic       last;
    } payload_result_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic [7:0] rx_byte = 8'h00;
    logic       out_stall = 1'b0;
    logic       in_stall;
    logic       out_valid;
    logic [7:0] data_byte;
    logic [4:0] byte_index;
    logic [7:0] frame_type;
    logic [7:0] seq_num;
    logic [7:0] received_check;
    logic       approved;
    logic       last;

    // frame parser state
    fprx_pkg::phase_t rx_phase;
    logic [5:0]       body_cnt;
    logic [7:0]       type_q;
    logic [7:0]       pay_q [NB];
    logic [7:0]       seq_q;
    logic [7:0]       xor_acc;

    payload_result_t pending_payload [$];

    int err_cnt = 0;
    int bytes_sent = 0;
    int gap_pct = 0;
    int stall_pct = 0;
    int hold_req_len = 0;
    int hold_req_id = 0;
    int hold_seen_id = 0;
    int hold_left = 0;

    framed_packet_receiver_xor_check_core #(
        .PAYLOAD_BYTES(NB)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .data_byte     (data_byte),
        .byte_index    (byte_index),
        .frame_type    (frame_type),
        .seq_num       (seq_num),
        .received_check(received_check),
        .approved      (approved),
        .last          (last)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        #400000;
        $display("CHECK FAILED");
        $finish;
    end

    task automatic flag_error(input string msg);
        $display("ERROR %0t: %s", $time, msg);
        err_cnt++;
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] exp);
        if (got !== exp)
            flag_error($sformatf("%s got %02h exp %02h", name, got, exp));
    endtask

    function automatic void parser_reset();
        rx_phase = fprx_pkg::PH_WAIT;
        body_cnt = '0;
        type_q   = '0;
        seq_q    = '0;
        xor_acc  = '0;
        for (int i = 0; i < NB; i++)
            pay_q[i] = '0;
    endfunction

    function automatic void parse_rx_byte(input logic [7:0] b);
        payload_result_t r;
        case (rx_phase)
            fprx_pkg::PH_WAIT:
            begin
                if (b == fprx_pkg::START_DELIM)
                begin
                    body_cnt = '0;
                    xor_acc  = '0;
                    rx_phase = fprx_pkg::PH_TYPE;
                end
            end
            fprx_pkg::PH_TYPE:
            begin
                body_cnt = '0;
                if (b != fprx_pkg::START_DELIM)
                begin
                    type_q   = b;
                    xor_acc  = b;
                    rx_phase = fprx_pkg::PH_BODY;
                end
            end
            fprx_pkg::PH_BODY:
            begin
                if (body_cnt < NB)
                begin
                    pay_q[body_cnt[NB_AW-1:0]] = b;
                    xor_acc  ^= b;
                    body_cnt = body_cnt + 6'd1;
                end
                else if (body_cnt == NB)
                begin
                    seq_q    = b;
                    xor_acc  ^= b;
                    body_cnt = body_cnt + 6'd1;
                end
                else
                begin
                    if (body_cnt == NB + 1)
                    begin
                        for (int i = 0; i < NB; i++)
                        begin
                            r.data  = pay_q[i];
                            r.idx   = i[4:0];
                            r.ftype = type_q;
                            r.seq   = seq_q;
                            r.chk   = b;
                            r.ok    = (b == xor_acc);
                            r.last  = (i == NB - 1);
                            pending_payload.insert(pending_payload.size(), r);
                        end
                    end
                    rx_phase = fprx_pkg::PH_WAIT;
                    body_cnt = '0;
                end
            end
            default:
            begin
                rx_phase = fprx_pkg::PH_WAIT;
                body_cnt = '0;
            end
        endcase
    endfunction

    // output side: random stall, plus long hold-off on request
    always @(posedge clk)
    begin
        if (hold_req_id != hold_seen_id)
        begin
            hold_seen_id = hold_req_id;
            hold_left    = hold_req_len;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin : result_check
        payload_result_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_payload.size() == 0)
                flag_error($sformatf("unexpected transfer data %02h idx %0d",
                                     data_byte, byte_index));
            else
            begin
                e = pending_payload[0];
                pending_payload.delete(0);
                check_field("data_byte", data_byte, e.data);
                check_field("byte_index", 8'(byte_index), 8'(e.idx));
                check_field("frame_type", frame_type, e.ftype);
                check_field("seq_num", seq_num, e.seq);
                check_field("received_check", received_check, e.chk);
                check_field("approved", 8'(approved), 8'(e.ok));
                check_field("last", 8'(last), 8'(e.last));
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < gap_pct)
        begin
            in_valid <= 1'b0;
            rx_byte  <= 8'($urandom);
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do
            @(posedge clk);
        while (in_stall);
        parse_rx_byte(b);
        bytes_sent++;
    endtask

    task automatic rest_sender();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_drained();
        while (pending_payload.size() != 0)
            @(posedge clk);
    endtask

    // chk < 0 sends the correct check byte
    task automatic send_frame(input logic [7:0] ftype, input logic [7:0] pl [NB],
                              input logic [7:0] seq, input int chk,
                              input bit restart);
        logic [7:0] x;
        x = ftype ^ seq;
        for (int i = 0; i < NB; i++)
            x ^= pl[i];
        send_byte(fprx_pkg::START_DELIM);
        if (restart)
            send_byte(fprx_pkg::START_DELIM);
        send_byte(ftype);
        for (int i = 0; i < NB; i++)
            send_byte(pl[i]);
        send_byte(seq);
        send_byte(chk < 0 ? x : chk[7:0]);
    endtask

    task automatic send_random_frame();
        logic [7:0] pl [NB];
        logic [7:0] ft;
        int         chk;
        do
            ft = 8'($urandom);
        while (ft == fprx_pkg::START_DELIM);
        for (int i = 0; i < NB; i++)
            pl[i] = ($urandom_range(9) == 0) ? fprx_pkg::START_DELIM : 8'($urandom);
        chk = ($urandom_range(99) < 30) ? int'($urandom_range(255)) : -1;
        send_frame(ft, pl, 8'($urandom), chk, $urandom_range(99) < 15);
    endtask

    task automatic test_directed();
        logic [7:0] pl [NB];
        gap_pct   = 0;
        stall_pct = 0;
        send_byte(8'h00);
        // restart on doubled delimiter, extremes, bad check
        pl = '{8'h00, 8'hFF, fprx_pkg::START_DELIM, 8'h01, 8'h80, 8'h7F, 8'h55, 8'hAA};
        send_frame(8'hFF, pl, 8'h00, 8'h00, 1'b1);
        // delimiter throughout the body, good check of FF
        for (int i = 0; i < NB; i++)
            pl[i] = fprx_pkg::START_DELIM;
        send_frame(8'h00, pl, 8'hFF, -1, 1'b0);
        rest_sender();
        wait_drained();
    endtask

    task automatic test_random_phase(input int n_items, input int gp, input int sp);
        int stop_at;
        int kind;
        int len;
        gap_pct   = gp;
        stall_pct = sp;
        stop_at   = bytes_sent + n_items;
        while (bytes_sent < stop_at)
        begin
            kind = $urandom_range(99);
            if (kind < 75)
                send_random_frame();
            else if (kind < 88)
            begin
                len = $urandom_range(4, 1);
                repeat (len) send_byte(8'($urandom));
            end
            else
            begin
                // truncated frame, later bytes run into it
                send_byte(fprx_pkg::START_DELIM);
                len = $urandom_range(10);
                repeat (len) send_byte(8'($urandom));
            end
        end
        rest_sender();
        wait_drained();
    endtask

    task automatic test_long_hold();
        gap_pct      = 0;
        stall_pct    = 0;
        hold_req_len = 150;
        hold_req_id++;
        repeat (3) send_random_frame();
        rest_sender();
        wait_drained();
        send_random_frame();
        rest_sender();
        wait_drained();
    endtask

    initial
    begin
        parser_reset();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_phase(80, 0, 0);
        test_random_phase(80, 80, 0);
        test_random_phase(80, 0, 80);
        test_long_hold();
        test_random_phase(80, 36, 36);

        stall_pct = 0;
        repeat (4 * NB) @(posedge clk);
        if (err_cnt == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
